// File: hdl/rob_pkg.sv
// ----------------------------------------------------------------------------
// Reorder buffer package
// Shared constants and types for the reorder buffer commit block.
// ----------------------------------------------------------------------------
package rob_pkg;

	localparam int Slots  = 16;
	localparam int PtrW   = $clog2(Slots);
	localparam int InW    = 3 + 4 + 2 + 1 + 5 + 1 + 32 + 1 + 32 + 32;
	localparam int InBytesW  = ((InW + 7) / 8) * 8;
	localparam int OutW   = 1 + 4 + 1 + 5 + 32 + 4 + 1 + 1 + 32 + 1 + 32;
	localparam int OutBytesW = ((OutW + 7) / 8) * 8;

	localparam logic [2:0] OpTick   = 3'd0;
	localparam logic [2:0] OpIssue  = 3'd1;
	localparam logic [2:0] OpAlu    = 3'd2;
	localparam logic [2:0] OpLoad   = 3'd3;
	localparam logic [2:0] OpStore  = 3'd4;
	localparam logic [2:0] OpMemDone = 3'd5;
	localparam logic [2:0] OpQuery  = 3'd6;

	localparam logic [1:0] KindReg    = 2'd0;
	localparam logic [1:0] KindStore  = 2'd1;
	localparam logic [1:0] KindBranch = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic        ready;
		logic        dest;
		logic        value_ok;
		logic        ppc_ok;
		logic        rpc_ok;
		logic        addr_ok;
		logic        sdata_ok;
		logic        sstate;
		logic        released;
		logic [4:0]  dest_reg;
		logic [31:0] value;
		logic [31:0] ppc;
		logic [31:0] rpc;
	} slot_t;

	typedef struct packed {
		logic        not_full;
		logic [3:0]  next_entry;
		logic        reg_write;
		logic [4:0]  reg_index;
		logic [31:0] reg_value;
		logic [3:0]  head_entry;
		logic        store_go;
		logic        flush;
		logic [31:0] redirect_pc;
		logic        query_hit;
		logic [31:0] query_value;
	} result_t;

endpackage

// File: hdl/reorder_buffer_commit.sv
// ----------------------------------------------------------------------------
// Reorder buffer commit
// Sixteen-slot circular reorder buffer with in-order commit.
// ----------------------------------------------------------------------------
// One event word is taken per cycle and gives one result word: the event is
// registered, applied to the slot storage in a single pass, and the result is
// held in an output register. A new word is accepted in every cycle unless a
// result word is waiting on m_tready, which stalls the input. Ticks commit or
// release the head entry, memory-done events retire it, other events fill or
// query one slot. Store address and data are kept by the memory side; only the
// release handshake lives here.
module reorder_buffer_commit import rob_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// operation, entry_id, entry_kind, dest_valid, dest_reg, pc_valid,
	// pc_value, data_valid, data_value, store_address
	input  logic [InBytesW-1:0]  s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// not_full, next_entry, reg_write, reg_index, reg_value, head_entry,
	// store_go, flush, redirect_pc, query_hit, query_value
	output logic [OutBytesW-1:0] m_tdata
);

	logic [InW-1:0] in_s1;
	logic           v_s1, adv;
	result_t        res, res_q;

	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			m_tvalid <= 1'b0;
			in_s1    <= '0;
		end else if (adv) begin
			v_s1     <= s_tvalid;
			m_tvalid <= v_s1;
			in_s1    <= s_tdata[InW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	rob_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.ev_valid   (v_s1 && adv),
		.operation  (in_s1[2:0]),
		.entry_id   (in_s1[6:3]),
		.entry_kind (in_s1[8:7]),
		.dest_valid (in_s1[9]),
		.dest_reg   (in_s1[14:10]),
		.pc_valid   (in_s1[15]),
		.pc_value   (in_s1[47:16]),
		.data_valid (in_s1[48]),
		.data_value (in_s1[80:49]),
		.res        (res)
	);

	assign m_tdata = OutBytesW'({res_q.query_value, res_q.query_hit, res_q.redirect_pc,
		res_q.flush, res_q.store_go, res_q.head_entry, res_q.reg_value,
		res_q.reg_index, res_q.reg_write, res_q.next_entry, res_q.not_full});

endmodule

// File: hdl/rob_core.sv
// ----------------------------------------------------------------------------
// Reorder buffer core
// Slot storage and pointers; applies one registered event per ev_valid cycle.
// ----------------------------------------------------------------------------
module rob_core import rob_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          ev_valid,
	input  logic [2:0]    operation,
	input  logic [3:0]    entry_id,
	input  logic [1:0]    entry_kind,
	input  logic          dest_valid,
	input  logic [4:0]    dest_reg,
	input  logic          pc_valid,
	input  logic [31:0]   pc_value,
	input  logic          data_valid,
	input  logic [31:0]   data_value,
	output result_t       res
);

	slot_t            slots_q [Slots];
	logic [Slots-1:0] live_q;
	logic [PtrW-1:0]  head_q, tail_q;
	logic             hold_q;

	logic [PtrW-1:0]  id, head_nx, tail_nx;
	logic             hold_nx, clear;
	slot_t            hs, qs, hs_eff, qs_eff;
	logic             commit_adv, rel, upd, do_issue;
	slot_t            nslot;

	assign id     = entry_id[PtrW-1:0];
	assign hs     = slots_q[head_q];
	assign qs     = slots_q[id];
	assign hs_eff = live_q[head_q] ? hs : '0;
	assign qs_eff = live_q[id] ? qs : '0;

	always_comb begin
		res        = '0;
		head_nx    = head_q;
		tail_nx    = tail_q;
		hold_nx    = hold_q;
		clear      = 1'b0;
		commit_adv = 1'b0;
		rel        = 1'b0;
		upd        = 1'b0;
		do_issue   = 1'b0;
		nslot      = qs_eff;
		if (operation == OpTick) begin
			hold_nx = 1'b0;
			if (head_q != tail_q && hs_eff.ready) begin
				unique case (hs_eff.kind)
					KindReg: begin
						if (hs_eff.value_ok) begin
							if (hs_eff.dest) begin
								res.reg_write  = 1'b1;
								res.reg_index  = hs_eff.dest_reg;
								res.reg_value  = hs_eff.value;
								res.head_entry = 4'(head_q);
							end
							commit_adv = 1'b1;
						end
					end
					KindStore: begin
						if (hs_eff.addr_ok && hs_eff.sdata_ok && hs_eff.sstate &&
								!hs_eff.released) begin
							res.store_go   = 1'b1;
							res.head_entry = 4'(head_q);
							rel            = 1'b1;
							nslot          = hs_eff;
							nslot.released = 1'b1;
						end
					end
					KindBranch: begin
						if (hs_eff.ppc_ok && hs_eff.rpc_ok &&
								!(hs_eff.dest && !hs_eff.value_ok)) begin
							if (hs_eff.dest) begin
								res.reg_write  = 1'b1;
								res.reg_index  = hs_eff.dest_reg;
								res.reg_value  = hs_eff.value;
								res.head_entry = 4'(head_q);
							end
							if (hs_eff.ppc != hs_eff.rpc) begin
								res.flush       = 1'b1;
								res.redirect_pc = hs_eff.rpc;
								clear           = 1'b1;
								hold_nx         = 1'b1;
							end else begin
								commit_adv = 1'b1;
							end
						end
					end
					default: ;
				endcase
			end
			if (commit_adv) head_nx = head_q + 1'b1;
			if (clear) begin
				head_nx = '0;
				tail_nx = '0;
			end
		end else if (!hold_q) begin
			unique case (operation)
				OpIssue: begin
					if (PtrW'(tail_q + 1'b1) != head_q && entry_kind != 2'd3) begin
						do_issue       = 1'b1;
						tail_nx        = tail_q + 1'b1;
						nslot          = '0;
						nslot.kind     = entry_kind;
						if (entry_kind == KindStore) begin
							nslot.sstate = 1'b1;
						end else begin
							nslot.dest     = dest_valid;
							nslot.dest_reg = dest_valid || entry_kind == KindReg ?
								dest_reg : 5'd0;
							if (entry_kind == KindBranch && pc_valid) begin
								nslot.ppc_ok = 1'b1;
								nslot.ppc    = pc_value;
							end
						end
					end
				end
				OpAlu: begin
					upd = 1'b1;
					if (pc_valid) begin
						nslot.rpc_ok = 1'b1;
						nslot.ready  = 1'b1;
						nslot.rpc    = pc_value;
					end
					if (data_valid) begin
						nslot.value_ok = 1'b1;
						nslot.ready    = 1'b1;
						nslot.value    = data_value;
					end
				end
				OpLoad: begin
					upd            = 1'b1;
					nslot.value_ok = 1'b1;
					nslot.ready    = 1'b1;
					nslot.value    = data_value;
				end
				OpStore: begin
					upd            = 1'b1;
					nslot.released = 1'b0;
					nslot.addr_ok  = 1'b1;
					nslot.sdata_ok = 1'b1;
					nslot.sstate   = 1'b1;
					nslot.ready    = 1'b1;
				end
				OpMemDone: begin
					if (head_q != tail_q) head_nx = head_q + 1'b1;
				end
				OpQuery: begin
					if (qs_eff.ready && qs_eff.value_ok) begin
						res.query_hit   = 1'b1;
						res.query_value = qs_eff.value;
					end
				end
				default: ;
			endcase
		end
		res.not_full   = PtrW'(tail_nx + 1'b1) != head_nx;
		res.next_entry = 4'(tail_nx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			hold_q <= 1'b0;
			live_q <= '0;
		end else if (ev_valid) begin
			head_q <= head_nx;
			tail_q <= tail_nx;
			hold_q <= hold_nx;
			if (clear) begin
				live_q <= '0;
			end else if (do_issue) begin
				live_q[tail_q] <= 1'b1;
			end else if (upd) begin
				live_q[id] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ev_valid && !clear) begin
			if (do_issue) begin
				slots_q[tail_q] <= nslot;
			end else if (upd) begin
				slots_q[id] <= nslot;
			end else if (rel) begin
				slots_q[head_q] <= nslot;
			end
		end
	end

endmodule

// File: hdl/rob_checker.sv
// ----------------------------------------------------------------------------
// Reorder buffer checker
// Port-level assertions for the reorder buffer commit block.
// ----------------------------------------------------------------------------
module rob_checker import rob_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [OutBytesW-1:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result not held");
	a_flush_pc: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[48] |-> m_tdata[4:1] == 4'd0 && m_tdata[0]) else $error("flush ptr");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[47] && m_tdata[81])) else $error("store and query");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready) else $error("stall with empty output");

endmodule

bind reorder_buffer_commit rob_checker u_rob_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// File: tb/sv/reorder_buffer_commit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Reorder buffer commit testbench
// Streams issue, result, store, memory-done, query and tick event words into
// the reorder buffer and checks every result word against a cycle-free model
// of the buffer held here, with random idling on both sides of the stream.
// ----------------------------------------------------------------------------
module reorder_buffer_commit_tb;
	import rob_pkg::*;

	typedef struct packed {
		logic [31:0] store_address;
		logic [31:0] data_value;
		logic        data_valid;
		logic [31:0] pc_value;
		logic        pc_valid;
		logic [4:0]  dest_reg;
		logic        dest_valid;
		logic [1:0]  entry_kind;
		logic [3:0]  entry_id;
		logic [2:0]  operation;
	} event_t;

	typedef struct packed {
		logic [31:0] query_value;
		logic        query_hit;
		logic [31:0] redirect_pc;
		logic        flush;
		logic        store_go;
		logic [3:0]  head_entry;
		logic [31:0] reg_value;
		logic [4:0]  reg_index;
		logic        reg_write;
		logic [3:0]  next_entry;
		logic        not_full;
	} outcome_t;

	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready;
	logic [InBytesW-1:0] s_tdata;
	logic [OutBytesW-1:0] m_tdata;
	logic s_fire;

	reorder_buffer_commit u_top (.*);

	// Model state.
	logic [3:0]  rob_head, rob_tail;
	logic        rob_hold;
	logic [1:0]  rob_kind [Slots];
	logic        f_ready [Slots], f_dest [Slots], f_value [Slots], f_ppc [Slots];
	logic        f_rpc [Slots], f_addr [Slots], f_sdata [Slots], f_sstate [Slots];
	logic        f_rel [Slots];
	logic [4:0]  rob_dest [Slots];
	logic [31:0] rob_value [Slots], rob_ppc [Slots], rob_rpc [Slots];

	event_t   event_q [$];
	outcome_t expected_q [$];
	int       errors, checked, idle_in, idle_out, n_flush, n_store, n_write;
	bit       done_driving;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		errors++;
		$display("mismatch #%0d word %0d %s: got %h want %h", errors, checked, what, got, want);
	endtask

	function automatic void clear_slot(input int s);
		rob_kind[s] = KindReg; f_ready[s] = 0; f_dest[s] = 0; f_value[s] = 0;
		f_ppc[s] = 0; f_rpc[s] = 0; f_addr[s] = 0; f_sdata[s] = 0; f_sstate[s] = 0;
		f_rel[s] = 0; rob_dest[s] = 0; rob_value[s] = 0; rob_ppc[s] = 0; rob_rpc[s] = 0;
	endfunction

	function automatic void clear_rob();
		rob_head = 0; rob_tail = 0;
		for (int s = 0; s < Slots; s++) clear_slot(s);
	endfunction

	function automatic void commit_head(inout outcome_t o);
		logic [3:0] h;
		h = rob_head;
		if (h == rob_tail || !f_ready[h]) return;
		if (rob_kind[h] == KindReg) begin
			if (!f_value[h]) return;
			if (f_dest[h]) begin
				o.reg_write = 1; o.reg_index = rob_dest[h]; o.reg_value = rob_value[h];
				o.head_entry = h;
			end
			rob_head = h + 1;
		end else if (rob_kind[h] == KindStore) begin
			if (!f_addr[h] || !f_sdata[h] || !f_sstate[h] || f_rel[h]) return;
			o.store_go = 1; o.head_entry = h; f_rel[h] = 1;
		end else if (rob_kind[h] == KindBranch) begin
			if (!f_ppc[h] || !f_rpc[h] || (f_dest[h] && !f_value[h])) return;
			if (f_dest[h]) begin
				o.reg_write = 1; o.reg_index = rob_dest[h]; o.reg_value = rob_value[h];
				o.head_entry = h;
			end
			if (rob_ppc[h] != rob_rpc[h]) begin
				o.flush = 1; o.redirect_pc = rob_rpc[h];
				clear_rob();
				rob_hold = 1;
				return;
			end
			rob_head = h + 1;
		end
	endfunction

	function automatic outcome_t rob_step(input event_t e);
		outcome_t o;
		logic [3:0] t, id;
		o = '0;
		id = e.entry_id;
		if (e.operation == OpTick) begin
			rob_hold = 0;
			commit_head(o);
		end else if (!rob_hold) begin
			case (e.operation)
				OpIssue: begin
					t = rob_tail;
					if (4'(t + 1) != rob_head && e.entry_kind != 2'd3) begin
						clear_slot(t);
						rob_kind[t] = e.entry_kind;
						if (e.entry_kind == KindReg) begin
							f_dest[t] = e.dest_valid; rob_dest[t] = e.dest_reg;
						end else if (e.entry_kind == KindStore) begin
							f_sstate[t] = 1;
						end else begin
							if (e.pc_valid) begin f_ppc[t] = 1; rob_ppc[t] = e.pc_value; end
							if (e.dest_valid) begin f_dest[t] = 1; rob_dest[t] = e.dest_reg; end
						end
						rob_tail = t + 1;
					end
				end
				OpAlu: begin
					if (e.pc_valid) begin
						f_rpc[id] = 1; f_ready[id] = 1; rob_rpc[id] = e.pc_value;
					end
					if (e.data_valid) begin
						f_value[id] = 1; f_ready[id] = 1; rob_value[id] = e.data_value;
					end
				end
				OpLoad: begin
					f_value[id] = 1; f_ready[id] = 1; rob_value[id] = e.data_value;
				end
				OpStore: begin
					f_rel[id] = 0; f_addr[id] = 1; f_sdata[id] = 1; f_sstate[id] = 1;
					f_ready[id] = 1;
				end
				OpMemDone: if (rob_head != rob_tail) rob_head = rob_head + 1;
				OpQuery: if (f_ready[id] && f_value[id]) begin
					o.query_hit = 1; o.query_value = rob_value[id];
				end
				default: ;
			endcase
		end
		o.not_full = (4'(rob_tail + 1) != rob_head);
		o.next_entry = rob_tail;
		return o;
	endfunction

	function automatic event_t rand_event();
		event_t e;
		e.operation = 3'($urandom_range(0, 7));
		e.entry_id = 4'($urandom); e.entry_kind = 2'($urandom);
		e.dest_valid = 1'($urandom); e.dest_reg = 5'($urandom);
		e.pc_valid = 1'($urandom); e.pc_value = $urandom;
		e.data_valid = 1'($urandom); e.data_value = $urandom;
		e.store_address = $urandom;
		return e;
	endfunction

	function automatic event_t mk(input logic [2:0] op, input logic [3:0] id,
			input logic [1:0] kind, input logic pcv, input logic [31:0] pc,
			input logic dv, input logic [31:0] data);
		event_t e;
		e = rand_event();
		e.operation = op; e.entry_id = id; e.entry_kind = kind;
		e.pc_valid = pcv; e.pc_value = pc; e.data_valid = dv; e.data_value = data;
		return e;
	endfunction

	// Well-formed instruction groups with random content: issue at the tail slot,
	// complete it, then tick and drain.
	task automatic push_group(inout logic [3:0] tail_guess);
		logic [1:0] k;
		logic [31:0] pc;
		event_t e;
		k = 2'($urandom_range(0, 2));
		pc = $urandom;
		e = mk(OpIssue, 0, k, 1, pc, 0, 0);
		event_q.push_back(e);
		if ($urandom_range(0, 9) == 0) event_q.push_back(mk(OpQuery, tail_guess, 0, 0, 0, 0, 0));
		case (k)
			KindReg: event_q.push_back(mk($urandom_range(0, 1) ? OpAlu : OpLoad, tail_guess,
				0, 1'($urandom), $urandom, 1, $urandom));
			KindStore: event_q.push_back(mk(OpStore, tail_guess, 0, 0, 0, 0, $urandom));
			default: event_q.push_back(mk(OpAlu, tail_guess, 0, 1,
				($urandom_range(0, 3) == 0) ? $urandom : pc, 1'($urandom), $urandom));
		endcase
		event_q.push_back(mk(OpQuery, tail_guess, 0, 0, 0, 0, 0));
		event_q.push_back(mk(OpTick, 0, 0, 0, 0, 0, 0));
		if (k == KindStore) event_q.push_back(mk(OpMemDone, 0, 0, 0, 0, 0, 0));
		tail_guess = tail_guess + 1;
	endtask

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Acceptance seen at the rising edge, used by the driver at the next falling edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) s_fire <= 0;
		else s_fire <= s_tvalid && s_tready;
	end

	// Driver.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 0;
			s_tdata <= '0;
		end else if (!s_tvalid || s_fire) begin
			if (event_q.size() != 0 && $urandom_range(0, 99) >= idle_in) begin
				s_tvalid <= 1;
				s_tdata <= InBytesW'(event_q.pop_front());
			end else begin
				s_tvalid <= 0;
			end
		end
	end

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) m_tready <= 0;
		else m_tready <= ($urandom_range(0, 99) >= idle_out);
	end

	// Prediction at acceptance, checking at result.
	always @(posedge clk) begin
		outcome_t got, want;
		if (arst_n && s_tvalid && s_tready) begin
			want = rob_step(event_t'(s_tdata[InW-1:0]));
			if (want.flush) n_flush++;
			if (want.store_go) n_store++;
			if (want.reg_write) n_write++;
			expected_q.push_back(want);
		end
		if (arst_n && m_tvalid && m_tready) begin
			got = outcome_t'(m_tdata[OutW-1:0]);
			if (expected_q.size() == 0) begin
				report("unexpected word", 0, 0);
			end else begin
				want = expected_q.pop_front();
				if (got.not_full !== want.not_full) report("not_full", got.not_full, want.not_full);
				if (got.next_entry !== want.next_entry)
					report("next_entry", got.next_entry, want.next_entry);
				if (got.reg_write !== want.reg_write) report("reg_write", got.reg_write, want.reg_write);
				if (got.reg_index !== want.reg_index) report("reg_index", got.reg_index, want.reg_index);
				if (got.reg_value !== want.reg_value) report("reg_value", got.reg_value, want.reg_value);
				if (got.head_entry !== want.head_entry)
					report("head_entry", got.head_entry, want.head_entry);
				if (got.store_go !== want.store_go) report("store_go", got.store_go, want.store_go);
				if (got.flush !== want.flush) report("flush", got.flush, want.flush);
				if (got.redirect_pc !== want.redirect_pc)
					report("redirect_pc", got.redirect_pc, want.redirect_pc);
				if (got.query_hit !== want.query_hit) report("query_hit", got.query_hit, want.query_hit);
				if (got.query_value !== want.query_value)
					report("query_value", got.query_value, want.query_value);
			end
			checked++;
		end
	end

	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		logic [3:0] tg;
		int phase_idle_in [4];
		int phase_idle_out [4];
		phase_idle_in = '{0, 75, 0, 17};
		phase_idle_out = '{0, 0, 75, 17};
		arst_n = 0; s_tvalid = 0; m_tready = 0; s_tdata = '0;
		errors = 0; checked = 0; idle_in = 0; idle_out = 0;
		rob_hold = 0; clear_rob();
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1;

		// Directed: fill to full, overfull issue, kind 3, every op, extremes.
		for (int i = 0; i < 16; i++)
			event_q.push_back(mk(OpIssue, 0, KindReg, 0, 0, 0, 0));
		event_q.push_back(mk(OpIssue, 0, 2'd3, 1, 32'hffff_ffff, 1, 32'hffff_ffff));
		event_q.push_back(mk(OpAlu, 0, 0, 1, 32'hffff_ffff, 1, 32'hffff_ffff));
		event_q.push_back(mk(OpQuery, 0, 0, 0, 0, 0, 0));
		event_q.push_back(mk(OpLoad, 4'd15, 0, 0, 0, 0, 0));
		event_q.push_back(mk(OpStore, 4'd1, 0, 0, 0, 0, 32'hffff_ffff));
		event_q.push_back(mk(3'd7, 4'd15, 0, 0, 0, 0, 0));
		event_q.push_back(mk(OpTick, 0, 0, 0, 0, 0, 0));
		event_q.push_back(mk(OpMemDone, 0, 0, 0, 0, 0, 0));
		while (event_q.size() != 0) @(posedge clk);

		tg = 0;
		for (int ph = 0; ph < 4; ph++) begin
			idle_in = phase_idle_in[ph];
			idle_out = phase_idle_out[ph];
			for (int g = 0; g < 88; g++) begin
				if ($urandom_range(0, 3) == 0) begin
					for (int r = 0; r < 4; r++) event_q.push_back(rand_event());
				end else begin
					push_group(tg);
				end
			end
			// Hold off until the buffer has answered everything so far.
			while (event_q.size() != 0 || expected_q.size() != 0) @(posedge clk);
			// Resync the tail guess after flushes and noise.
			tg = rob_tail;
		end
		for (int i = 0; i < 200; i++) event_q.push_back(mk(OpMemDone, 0, 0, 0, 0, 0, 0));
		for (int i = 0; i < 4; i++) event_q.push_back(mk(OpTick, 0, 0, 0, 0, 0, 0));
		while (event_q.size() != 0) @(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("Checked %0d result words: %0d register writes, %0d store releases, %0d flushes.",
			checked, n_write, n_store, n_flush);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
